FILE: design/rcur_pkg.sv
package rcur_pkg;

    localparam int CHANNELS = 3;

    // operation codes carried in tuser
    localparam logic OP_PIN   = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // register byte addresses on the APB port
    localparam logic [3:0] ADDR_DEBOUNCE = 4'h0;
    localparam logic [3:0] ADDR_MIN_POS  = 4'h4;
    localparam logic [3:0] ADDR_MAX_POS  = 4'h8;

    // quadrature transition steps, index = {prev A, prev B, A, B}
    localparam logic signed [1:0] STEP_LUT [16] = '{
        2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
        -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
    };

    localparam logic [15:0] DEBOUNCE_RST = 16'd200;
    localparam logic [3:0]  MIN_POS_RST  = 4'd0;
    localparam logic [3:0]  MAX_POS_RST  = 4'd2;
    localparam logic [3:0]  HIST_RST     = 4'd3;

    typedef struct packed {
        logic        op;
        logic        pin_a;
        logic        pin_b;
        logic [31:0] time_ms;
    } t_item;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [3:0]  min_position;
        logic [3:0]  max_position;
    } t_cfg;

    typedef struct packed {
        logic [3:0] cursor;
        logic [2:0] channel_states;
        logic       moved;
        logic       toggled;
    } t_res;

endpackage

FILE: design/rcur_core.sv
module rcur_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  rcur_pkg::t_item i_item,
    input  rcur_pkg::t_cfg  i_cfg,
    output rcur_pkg::t_res  o_res
);

    logic [3:0]                   r_hist, n_hist;
    logic signed [3:0]            r_sum, n_sum;
    logic [3:0]                   r_cursor, n_cursor;
    logic [31:0]                  r_last, n_last;
    logic [rcur_pkg::CHANNELS-1:0] r_chan, n_chan;

    logic [3:0]        hist_new;
    logic signed [3:0] sum_add;
    logic signed [5:0] pos_step, pos_clamp;
    logic [31:0]       elapsed;
    logic              moved, toggled;

    function automatic logic signed [3:0] STEP_EXT(input logic signed [1:0] s);
        return 4'(s);
    endfunction

    always_comb begin
        n_hist   = r_hist;
        n_sum    = r_sum;
        n_cursor = r_cursor;
        n_last   = r_last;
        n_chan   = r_chan;
        moved    = 1'b0;
        toggled  = 1'b0;

        hist_new = {r_hist[1:0], i_item.pin_a, i_item.pin_b};
        sum_add  = r_sum + 4'(STEP_EXT(rcur_pkg::STEP_LUT[hist_new]));
        pos_step = $signed({2'b00, r_cursor}) + ((sum_add > 4'sd3) ? 6'sd1 : -6'sd1);
        // max first, then min: min wins when the range is inverted
        pos_clamp = pos_step;
        if (pos_clamp > $signed({2'b00, i_cfg.max_position})) begin
            pos_clamp = $signed({2'b00, i_cfg.max_position});
        end
        if (pos_clamp < $signed({2'b00, i_cfg.min_position})) begin
            pos_clamp = $signed({2'b00, i_cfg.min_position});
        end
        elapsed = i_item.time_ms - r_last;

        if (i_item.op == rcur_pkg::OP_PIN) begin
            n_hist = hist_new;
            n_sum  = sum_add;
            if (sum_add > 4'sd3 || sum_add < -4'sd3) begin
                n_cursor = pos_clamp[3:0];
                moved    = (pos_clamp[3:0] != r_cursor);
                n_sum    = 4'sd0;
            end
        end else begin
            n_last = i_item.time_ms;
            if (elapsed > {16'd0, i_cfg.debounce_ms} &&
                {28'd0, r_cursor} < 32'(rcur_pkg::CHANNELS)) begin
                n_chan  = r_chan ^ (rcur_pkg::CHANNELS'(1) << r_cursor);
                toggled = 1'b1;
            end
        end

        o_res.cursor         = n_cursor;
        o_res.channel_states = 3'(n_chan);
        o_res.moved          = moved;
        o_res.toggled        = toggled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= rcur_pkg::HIST_RST;
            r_sum    <= 4'sd0;
            r_cursor <= 4'd0;
            r_last   <= 32'd0;
            r_chan   <= '0;
        end else if (i_en) begin
            r_hist   <= n_hist;
            r_sum    <= n_sum;
            r_cursor <= n_cursor;
            r_last   <= n_last;
            r_chan   <= n_chan;
        end
    end

`ifndef ASSERT_OFF
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= 4'sd3 && r_sum >= -4'sd3)
        else $error("detent sum out of range");

    a_press_keeps_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.op == rcur_pkg::OP_PRESS) |=> $stable(r_cursor) && $stable(r_sum))
        else $error("press moved the cursor");

    a_pin_keeps_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.op == rcur_pkg::OP_PIN) |=> $stable(r_chan) && $stable(r_last))
        else $error("pin sample touched press state");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_chan) && $stable(r_cursor) && $stable(r_hist))
        else $error("state changed with no request");

    a_toggle_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.toggled) |=> $countones(r_chan ^ $past(r_chan)) == 1)
        else $error("toggle flipped other than one channel");
`endif

endmodule

FILE: design/rotary_cursor_with_toggle_button.sv
// Channel   Direction  Handshake                  Payload
// s_*       in         i_s_tvalid / o_s_tready    tuser: operation; tdata: pin_a, pin_b, time_ms
// m_*       out        o_m_tvalid / i_m_tready    tdata: cursor, channel_states, moved, toggled
// APB       in         psel, penable, pwrite      debounce_ms @0x0, min_position @0x4,
//                                                 max_position @0x8
//
// One request per cycle sustained unless the result stream stalls; a request passes the input
// register, then the result register, before o_m_tvalid. The detent state is updated in the
// same cycle the request leaves the input register, so consecutive requests chain directly.
// Reset (synchronous, active low) empties both registers and restores all state.
// A stalled result stage holds the input register; tready drops only when both are full.
module rotary_cursor_with_toggle_button (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // [0] pin_a, [1] pin_b, [33:2] time_ms, [39:34] zero
    input  logic        i_s_tuser,  // [0] operation
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // [3:0] cursor, [6:4] channel_states, [7] moved,
                                    // [8] toggled, [15:9] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rcur_pkg::t_cfg  r_cfg;
    rcur_pkg::t_item r_in;
    rcur_pkg::t_res  r_out;
    rcur_pkg::t_res  core_res;
    logic            r_in_valid;
    logic            r_out_valid;
    logic            advance;
    logic            cfg_wr;

    // ---- configuration registers ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms  <= rcur_pkg::DEBOUNCE_RST;
            r_cfg.min_position <= rcur_pkg::MIN_POS_RST;
            r_cfg.max_position <= rcur_pkg::MAX_POS_RST;
        end else if (cfg_wr) begin
            case (paddr)
                rcur_pkg::ADDR_DEBOUNCE: r_cfg.debounce_ms  <= pwdata[15:0];
                rcur_pkg::ADDR_MIN_POS:  r_cfg.min_position <= pwdata[3:0];
                rcur_pkg::ADDR_MAX_POS:  r_cfg.max_position <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            rcur_pkg::ADDR_DEBOUNCE: prdata = {16'd0, r_cfg.debounce_ms};
            rcur_pkg::ADDR_MIN_POS:  prdata = {28'd0, r_cfg.min_position};
            rcur_pkg::ADDR_MAX_POS:  prdata = {28'd0, r_cfg.max_position};
            default:                 prdata = 32'd0;
        endcase
    end

    // ---- input register ----
    // the request in r_in moves on whenever the result slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.op      <= i_s_tuser;
            r_in.pin_a   <= i_s_tdata[0];
            r_in.pin_b   <= i_s_tdata[1];
            r_in.time_ms <= i_s_tdata[33:2];
        end
    end

    // ---- decode and state update ----
    rcur_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out.toggled, r_out.moved, r_out.channel_states, r_out.cursor};

endmodule
